// File: src/psnr_pkg.sv
package psnr_pkg;

    // Frame size limit and derived widths
    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int PIX_W    = 8;
    localparam int DEPTH_W  = 5;
    localparam int CNT_W    = MAX_PIXELS_LOG2 + 1;
    localparam int SQ_W     = 2 * PIX_W;
    localparam int SUM_W    = SQ_W + MAX_PIXELS_LOG2;
    localparam int PEAK_W   = 16;
    localparam int PEAK2_W  = 2 * PEAK_W;
    localparam int NUM_W    = PEAK2_W + CNT_W;
    localparam int MSE_FRAC = 8;
    localparam int DVD_W    = SUM_W + MSE_FRAC;
    localparam int MSE_W    = 24;
    localparam int PSNR_W   = 17;
    localparam int GRADE_W  = 3;
    localparam int SCALE_W  = SUM_W + 14;

    // log2 unit
    localparam int LOG_FRAC = 24;
    localparam int NORM_W   = 64;
    localparam int LZ_W     = 6;
    localparam int MANT_W   = 32;
    localparam int LOG_W    = LZ_W + LOG_FRAC;
    localparam int PROD_W   = LOG_W + 32;
    localparam int RND_W    = LOG_W + 12;

    // Sequencer step counter
    localparam int STEP_W    = 6;
    localparam int DIV_STEPS = DVD_W;
    localparam int GRADE_STEPS = 3;

    localparam logic [CNT_W-1:0]   MAX_COUNT   = CNT_W'(1) << MAX_PIXELS_LOG2;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(8);
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(16);
    localparam logic [31:0]        LOG10_2_Q32 = 32'd1292913986;

    // Quality grades
    localparam logic [GRADE_W-1:0] GRADE_PERFECT   = GRADE_W'(0);
    localparam logic [GRADE_W-1:0] GRADE_EXCELLENT = GRADE_W'(1);
    localparam logic [GRADE_W-1:0] GRADE_GOOD      = GRADE_W'(2);
    localparam logic [GRADE_W-1:0] GRADE_FAIR      = GRADE_W'(3);
    localparam logic [GRADE_W-1:0] GRADE_POOR      = GRADE_W'(4);

    // Grade compare steps: threshold 100x, 1000x, 10000x the error sum
    localparam logic [1:0] GSTEP_20DB = 2'd0;
    localparam logic [1:0] GSTEP_30DB = 2'd1;
    localparam logic [1:0] GSTEP_40DB = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       in_ready;
        logic       latch;
        logic       prep;
        logic       grade_step;
        logic [1:0] grade_idx;
        logic       div_step;
        logic       log_load;
        logic       log_sel;
        logic       log_norm;
        logic       log_iter;
        logic       log_store;
        logic       diff;
        logic       scale;
        logic       rnd;
        logic       out_load;
    } psnr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic ident;
        logic norm_done;
        logic out_free;
    } psnr_status_t;

    // peak^2 with peak = 2^depth - 1, depth clamped to 1..16
    function automatic logic [PEAK2_W-1:0] peak_squared(input logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W-1:0] d;
        logic [PEAK_W:0]    peak_full;
        logic [PEAK_W-1:0]  peak;
        d = depth;
        if (d < DEPTH_MIN)
            d = DEPTH_MIN;
        if (d > DEPTH_MAX)
            d = DEPTH_MAX;
        peak_full = (PEAK_W + 1)'(1) << d;
        peak = PEAK_W'(peak_full - (PEAK_W + 1)'(1));
        return PEAK2_W'(peak) * PEAK2_W'(peak);
    endfunction

endpackage

// File: src/psnr_if.sv
interface psnr_pixel_if;
    import psnr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] orig_pixel;
    logic [PIX_W-1:0] test_pixel;
    logic             last_pixel;

    modport source (output valid, orig_pixel, test_pixel, last_pixel, input ready);
    modport sink   (input valid, orig_pixel, test_pixel, last_pixel, output ready);
endinterface

interface psnr_result_if;
    import psnr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MSE_W-1:0]         mse_value;
    logic signed [PSNR_W-1:0] psnr_db;
    logic                     identical;
    logic [GRADE_W-1:0]       quality_grade;
    logic [CNT_W-1:0]         pixel_total;
    logic                     overflow;

    modport source (output valid, mse_value, psnr_db, identical, quality_grade,
                    pixel_total, overflow, input ready);
    modport sink   (input valid, mse_value, psnr_db, identical, quality_grade,
                    pixel_total, overflow, output ready);
endinterface

// File: src/psnr_ctrl.sv
module psnr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psnr_pkg::psnr_status_t status,
    output psnr_pkg::psnr_cmd_t    cmd
);
    import psnr_pkg::*;

    localparam logic [3:0] S_ACC       = 4'd0;
    localparam logic [3:0] S_LATCH     = 4'd1;
    localparam logic [3:0] S_PREP      = 4'd2;
    localparam logic [3:0] S_GRADE     = 4'd3;
    localparam logic [3:0] S_DIV       = 4'd4;
    localparam logic [3:0] S_LOG_LOAD  = 4'd5;
    localparam logic [3:0] S_LOG_NORM  = 4'd6;
    localparam logic [3:0] S_LOG_ITER  = 4'd7;
    localparam logic [3:0] S_LOG_STORE = 4'd8;
    localparam logic [3:0] S_DIFF      = 4'd9;
    localparam logic [3:0] S_SCALE     = 4'd10;
    localparam logic [3:0] S_ROUND     = 4'd11;
    localparam logic [3:0] S_OUT       = 4'd12;

    localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] LOG_LAST   = STEP_W'(LOG_FRAC - 1);
    localparam logic [STEP_W-1:0] GRADE_LAST = STEP_W'(GRADE_STEPS - 1);

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              sel_reg, sel_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.grade_idx = step_reg[1:0];
        cmd.log_sel   = sel_reg;
        case (state_reg)
            S_ACC:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid && status.in_last)
                    state_next = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.latch  = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = S_GRADE;
            end
            S_GRADE:
            begin
                cmd.grade_step = 1'b1;
                if (step_reg == GRADE_LAST)
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                sel_next     = 1'b0;
                if (step_reg == DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = status.ident ? S_OUT : S_LOG_LOAD;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_LOG_LOAD:
            begin
                cmd.log_load = 1'b1;
                state_next   = S_LOG_NORM;
            end
            S_LOG_NORM:
            begin
                cmd.log_norm = 1'b1;
                step_next    = '0;
                if (status.norm_done)
                    state_next = S_LOG_ITER;
            end
            S_LOG_ITER:
            begin
                cmd.log_iter = 1'b1;
                if (step_reg == LOG_LAST)
                    state_next = S_LOG_STORE;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_LOG_STORE:
            begin
                cmd.log_store = 1'b1;
                sel_next      = 1'b1;
                state_next    = sel_reg ? S_DIFF : S_LOG_LOAD;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            step_reg  <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
        end
    end

    // A transfer carrying the last mark starts the frame tail
    a_last_starts_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && status.in_valid && status.in_last) |=> state_reg == S_LATCH)
        else $error("last pixel did not start frame tail");

    // Iteration counter stays inside the divider length
    a_div_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> step_reg <= DIV_LAST)
        else $error("divider step counter out of range");

    // Second log pass always follows the first
    a_log_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOG_STORE && !sel_reg) |=> (state_reg == S_LOG_LOAD && sel_reg))
        else $error("log pass order broken");

endmodule

// File: src/psnr_datapath.sv
module psnr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psnr_pkg::psnr_cmd_t           cmd,
    output psnr_pkg::psnr_status_t        status,
    input  logic                          cfg_we,
    input  logic [psnr_pkg::DEPTH_W-1:0]  cfg_data,
    psnr_pixel_if.sink                    pixel,
    psnr_result_if.source                 result
);
    import psnr_pkg::*;

    localparam logic [LZ_W-1:0] TOP_BIT = LZ_W'(NORM_W - 1);

    logic [DEPTH_W-1:0] depth_reg;

    // Accumulators
    logic [SUM_W-1:0] acc_sum_reg;
    logic [CNT_W-1:0] acc_cnt_reg;
    logic             acc_ovf_reg;

    // Frame tail working registers
    logic [SUM_W-1:0]   w_sum_reg;
    logic [CNT_W-1:0]   w_cnt_reg;
    logic               w_ovf_reg;
    logic [PEAK2_W-1:0] peak2_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [GRADE_W-1:0] grade_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [NORM_W-1:0]  norm_reg;
    logic [LZ_W-1:0]    lz_reg;
    logic [MANT_W-1:0]  mant_reg, mant_next;
    logic [LOG_W-1:0]   log_reg, log_next;
    logic [LOG_W-1:0]   la_reg, lb_reg, mag_reg;
    logic               neg_reg;
    logic [LOG_W-1:0]   v_reg;
    logic [PSNR_W-1:0]  psnr_reg;

    // Output register
    logic               res_valid_reg;
    logic [MSE_W-1:0]   res_mse_reg;
    logic [PSNR_W-1:0]  res_psnr_reg;
    logic               res_ident_reg;
    logic [GRADE_W-1:0] res_grade_reg;
    logic [CNT_W-1:0]   res_total_reg;
    logic               res_ovf_reg;

    logic               in_xfer;
    logic [PIX_W-1:0]   pix_diff;
    logic [SQ_W-1:0]    pix_sq;
    logic [CNT_W:0]     trial;
    logic               fits;
    logic [2*MANT_W-1:0] mant_sq;
    logic [MANT_W:0]    mant_top;
    logic [PROD_W-1:0]  scale_prod;
    logic [RND_W-1:0]   rnd_sum;
    logic [PSNR_W-1:0]  q_val;
    logic               ident;

    assign in_xfer     = pixel.valid && pixel.ready;
    assign pixel.ready = cmd.in_ready;
    assign ident       = (w_sum_reg == '0);

    assign status.in_valid  = pixel.valid;
    assign status.in_last   = pixel.last_pixel;
    assign status.ident     = ident;
    assign status.norm_done = norm_reg[NORM_W-1];
    assign status.out_free  = !res_valid_reg || result.ready;

    // Squared pixel difference
    assign pix_diff = (pixel.orig_pixel >= pixel.test_pixel) ?
                      (pixel.orig_pixel - pixel.test_pixel) :
                      (pixel.test_pixel - pixel.orig_pixel);
    assign pix_sq   = SQ_W'(pix_diff) * SQ_W'(pix_diff);

    // Restoring divider step
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, w_cnt_reg});
    assign rem_next = fits ? CNT_W'(trial - {1'b0, w_cnt_reg}) : trial[CNT_W-1:0];

    // log2 squaring step
    assign mant_sq  = (2*MANT_W)'(mant_reg) * (2*MANT_W)'(mant_reg);
    assign mant_top = mant_sq[2*MANT_W-1:MANT_W-1];
    assign mant_next = mant_top[MANT_W] ? mant_top[MANT_W:1] : mant_top[MANT_W-1:0];
    assign log_next  = {log_reg[LOG_W-2:0], mant_top[MANT_W]};

    // dB scaling and rounding
    assign scale_prod = PROD_W'(mag_reg) * PROD_W'(LOG10_2_Q32);
    assign rnd_sum    = (RND_W'(v_reg) << 11) + (RND_W'(v_reg) << 9)
                        + (RND_W'(1) << (LOG_FRAC - 1));
    assign q_val      = rnd_sum[LOG_FRAC +: PSNR_W];

    // Bit depth register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= DEPTH_RESET;
        else if (cfg_we)
            depth_reg <= cfg_data;
    end

    // Frame accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sum_reg <= '0;
            acc_cnt_reg <= '0;
            acc_ovf_reg <= 1'b0;
        end
        else if (cmd.latch)
        begin
            acc_sum_reg <= '0;
            acc_cnt_reg <= '0;
            acc_ovf_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (acc_cnt_reg >= MAX_COUNT)
                acc_ovf_reg <= 1'b1;
            else
            begin
                acc_sum_reg <= acc_sum_reg + SUM_W'(pix_sq);
                acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Frame tail: snapshot, grade, divide
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            w_sum_reg <= acc_sum_reg;
            w_cnt_reg <= acc_cnt_reg;
            w_ovf_reg <= acc_ovf_reg;
            peak2_reg <= peak_squared(depth_reg);
            dvd_reg   <= {acc_sum_reg, MSE_FRAC'(0)};
            rem_reg   <= '0;
        end
        if (cmd.prep)
        begin
            num_reg   <= NUM_W'(peak2_reg) * NUM_W'(w_cnt_reg);
            scale_reg <= (SCALE_W'(w_sum_reg) << 6) + (SCALE_W'(w_sum_reg) << 5)
                         + (SCALE_W'(w_sum_reg) << 2);
            grade_reg <= GRADE_POOR;
        end
        if (cmd.grade_step)
        begin
            if (num_reg > NUM_W'(scale_reg))
            begin
                case (cmd.grade_idx)
                    GSTEP_20DB: grade_reg <= GRADE_FAIR;
                    GSTEP_30DB: grade_reg <= GRADE_GOOD;
                    GSTEP_40DB: grade_reg <= GRADE_EXCELLENT;
                    default:    grade_reg <= grade_reg;
                endcase
            end
            scale_reg <= (scale_reg << 3) + (scale_reg << 1);
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

    // Shared log2 unit: normalize, then one squaring per fraction bit
    always_ff @(posedge clk)
    begin
        if (cmd.log_load)
        begin
            if (cmd.log_sel)
                norm_reg <= NORM_W'(w_sum_reg);
            else if (num_reg == '0)
                norm_reg <= NORM_W'(1);
            else
                norm_reg <= NORM_W'(num_reg);
            lz_reg <= '0;
        end
        if (cmd.log_norm)
        begin
            if (norm_reg[NORM_W-1])
            begin
                mant_reg <= norm_reg[NORM_W-1 -: MANT_W];
                log_reg  <= LOG_W'(TOP_BIT - lz_reg);
            end
            else if (norm_reg[NORM_W-1 -: 8] == 8'd0)
            begin
                norm_reg <= norm_reg << 8;
                lz_reg   <= lz_reg + LZ_W'(8);
            end
            else
            begin
                norm_reg <= norm_reg << 1;
                lz_reg   <= lz_reg + LZ_W'(1);
            end
        end
        if (cmd.log_iter)
        begin
            mant_reg <= mant_next;
            log_reg  <= log_next;
        end
        if (cmd.log_store)
        begin
            if (cmd.log_sel)
                lb_reg <= log_reg;
            else
                la_reg <= log_reg;
        end
    end

    // log difference, scale to dB, round
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            neg_reg <= (la_reg < lb_reg);
            mag_reg <= (la_reg < lb_reg) ? (lb_reg - la_reg) : (la_reg - lb_reg);
        end
        if (cmd.scale)
            v_reg <= scale_prod[PROD_W-1:32];
        if (cmd.rnd)
            psnr_reg <= neg_reg ? (PSNR_W'(0) - q_val) : q_val;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.out_load)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_mse_reg   <= (w_cnt_reg == '0) ? '0 : dvd_reg[MSE_W-1:0];
            res_psnr_reg  <= ident ? '0 : psnr_reg;
            res_ident_reg <= ident;
            res_grade_reg <= ident ? GRADE_PERFECT : grade_reg;
            res_total_reg <= w_cnt_reg;
            res_ovf_reg   <= w_ovf_reg;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.mse_value     = res_mse_reg;
    assign result.psnr_db       = res_psnr_reg;
    assign result.identical     = res_ident_reg;
    assign result.quality_grade = res_grade_reg;
    assign result.pixel_total   = res_total_reg;
    assign result.overflow      = res_ovf_reg;

    // Pair count never passes the frame limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_cnt_reg <= MAX_COUNT)
        else $error("pair count beyond limit");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load && res_valid_reg && !result.ready))
        else $error("result register overwritten");

    // Accumulators are clear once the frame is snapshotted
    a_latch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (acc_sum_reg == '0 && acc_cnt_reg == '0 && !acc_ovf_reg))
        else $error("accumulators not cleared");

    // An identical frame reports zero dB and the perfect grade
    a_ident_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_ident_reg) |->
        (res_psnr_reg == '0 && res_grade_reg == GRADE_PERFECT))
        else $error("identical result with nonzero fields");

endmodule

// File: src/psnr_mse_accumulator.sv
// Channel  | Dir | Handshake       | Payload
// ---------+-----+-----------------+---------------------------------------------
// pixel    | in  | valid / ready   | orig_pixel, test_pixel, last_pixel
// result   | out | valid / ready   | mse_value, psnr_db, identical, quality_grade,
//          |     |                 | pixel_total, overflow
// cfg      | in  | cfg_we          | cfg_data (bit_depth)
//
// Pixel pairs transfer one per cycle while a frame accumulates.
// After the last-marked transfer, pixel.ready stays low while the frame tail
// runs: a 44-step bit-serial divider, then two passes of a shared log2 unit,
// each with a normalizing shift loop and 24 squaring steps. An identical
// frame skips the log2 unit.
// A finished result waits in the output register; a stall there holds the
// next frame tail only at its final step. Reset clears the accumulators,
// the sequencer and the result valid, and sets bit_depth to 8.
module psnr_mse_accumulator (
    input  logic                          clk,
    input  logic                          rst_n,
    psnr_pixel_if.sink                    pixel,
    psnr_result_if.source                 result,
    input  logic                          cfg_we,
    input  logic [psnr_pkg::DEPTH_W-1:0]  cfg_data
);
    import psnr_pkg::*;

    psnr_cmd_t    cmd;
    psnr_status_t status;

    // Sequencer
    psnr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Accumulators, divider, log2 unit and result register
    psnr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .pixel    (pixel),
        .result   (result)
    );

endmodule

// File: bench/psnr_mse_accumulator_test.sv
`timescale 1ns / 1ps

module psnr_mse_accumulator_test;
    import psnr_pkg::*;

    localparam int DRAIN_CYCLES   = 150;
    localparam int END_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 700;
    localparam int HOLD_AT_FRAME  = 8;
    localparam int PHASE_ITEMS    = 55;
    localparam int QUEUE_DEPTH    = 64;
    localparam int MAX_PRINTS     = 100;

    typedef enum int {
        FRAME_NOISE,
        FRAME_CLOSE,
        FRAME_SAME,
        FRAME_SPECK,
        FRAME_EXTREME
    } frame_style_t;

    typedef struct packed {
        logic [PIX_W-1:0] orig;
        logic [PIX_W-1:0] test;
        logic             last;
    } pixel_pair_t;

    typedef struct packed {
        logic [MSE_W-1:0]         mse;
        logic signed [PSNR_W-1:0] psnr;
        logic                     ident;
        logic [GRADE_W-1:0]       grade;
        logic [CNT_W-1:0]         total;
        logic                     ovf;
    } frame_score_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [DEPTH_W-1:0]  cfg_data;

    psnr_pixel_if  pix ();
    psnr_result_if res ();

    psnr_mse_accumulator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pix),
        .result   (res),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // pending pixel pairs and expected frame scores
    pixel_pair_t  pixel_q[$];
    frame_score_t frame_score_q[$];

    // shadow of the block state
    logic [SUM_W-1:0]   sq_err_acc = '0;
    logic [CNT_W-1:0]   pair_cnt   = '0;
    logic               cnt_ovf    = 1'b0;
    logic [DEPTH_W-1:0] cur_depth  = DEPTH_RESET;

    int          mismatches   = 0;
    int          frames_scored = 0;
    int unsigned quiet_cycles = 0;
    logic        pix_taken    = 1'b0;

    // sender pacing
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    pixel_pair_t next_pair;

    // receiver pacing
    int unsigned hold_left  = 0;
    logic        held_once  = 1'b0;
    int unsigned mode_left  = 0;
    logic [7:0]  stall_pat  = 8'hFF;
    logic [2:0]  pat_idx    = '0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // log2 in unsigned fixed point, LOG_FRAC fraction bits, by repeated squaring
    function automatic logic [63:0] log2_q24(input logic [63:0] x);
        int unsigned n;
        int          i;
        logic [63:0] m;
        logic [63:0] acc;
        n = 0;
        while (n < 63 && (x >> (n + 1)) != 0)
            n++;
        if (n >= 31)
            m = x >> (n - 31);
        else
            m = x << (31 - n);
        acc = 64'(n);
        for (i = 0; i < LOG_FRAC; i++)
        begin
            m = (m * m) >> 31;
            acc = acc << 1;
            if (m >= 64'h1_0000_0000)
            begin
                acc[0] = 1'b1;
                m = m >> 1;
            end
        end
        return acc;
    endfunction

    // accumulate one pair; on the last pair of a frame, score it and clear
    function automatic void score_pair(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                       input logic last);
        logic [PIX_W-1:0] d;
        int unsigned      depth;
        logic [63:0]      peak;
        logic [63:0]      num;
        logic [63:0]      sum;
        logic [63:0]      la;
        logic [63:0]      lb;
        logic [63:0]      mag;
        logic [63:0]      v;
        logic [63:0]      q;
        logic             neg;
        frame_score_t     s;
        if (pair_cnt >= MAX_COUNT)
            cnt_ovf = 1'b1;
        else
        begin
            d = (a >= b) ? a - b : b - a;
            sq_err_acc = sq_err_acc + SUM_W'(d) * SUM_W'(d);
            pair_cnt = pair_cnt + CNT_W'(1);
        end
        if (!last)
            return;

        depth = cur_depth;
        if (depth < 1)
            depth = 1;
        if (depth > 16)
            depth = 16;
        peak = (64'd1 << depth) - 64'd1;
        num  = peak * peak * 64'(pair_cnt);
        sum  = 64'(sq_err_acc);

        s.total = pair_cnt;
        s.ovf   = cnt_ovf;
        s.mse   = (pair_cnt != 0) ? MSE_W'((sum << MSE_FRAC) / 64'(pair_cnt)) : '0;
        if (sum == 0)
        begin
            s.ident = 1'b1;
            s.grade = GRADE_PERFECT;
            s.psnr  = '0;
        end
        else
        begin
            la  = log2_q24((num != 0) ? num : 64'd1);
            lb  = log2_q24(sum);
            neg = la < lb;
            mag = neg ? lb - la : la - lb;
            v   = (mag * 64'(LOG10_2_Q32)) >> 32;
            q   = (v * 64'd2560 + (64'd1 << (LOG_FRAC - 1))) >> LOG_FRAC;
            s.ident = 1'b0;
            s.psnr  = PSNR_W'(neg ? -q : q);
            if (num > 64'd10000 * sum)
                s.grade = GRADE_EXCELLENT;
            else if (num > 64'd1000 * sum)
                s.grade = GRADE_GOOD;
            else if (num > 64'd100 * sum)
                s.grade = GRADE_FAIR;
            else
                s.grade = GRADE_POOR;
        end
        frame_score_q.push_back(s);
        sq_err_acc = '0;
        pair_cnt   = '0;
        cnt_ovf    = 1'b0;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // sample both channels, predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            pix_taken <= pix.valid && pix.ready;
            if ((pix.valid && pix.ready) || (res.valid && res.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (pix.valid && pix.ready)
                score_pair(pix.orig_pixel, pix.test_pixel, pix.last_pixel);

            if (res.valid && res.ready)
            begin
                frames_scored <= frames_scored + 1;
                if (frame_score_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t result transfer with no frame pending: mse %0d psnr %0d",
                             $time, res.mse_value, res.psnr_db);
                end
                else
                begin
                    check_field("mse_value", frame_score_q[0].mse, res.mse_value);
                    check_field("psnr_db", frame_score_q[0].psnr, res.psnr_db);
                    check_field("identical", frame_score_q[0].ident, res.identical);
                    check_field("quality_grade", frame_score_q[0].grade, res.quality_grade);
                    check_field("pixel_total", frame_score_q[0].total, res.pixel_total);
                    check_field("overflow", frame_score_q[0].ovf, res.overflow);
                    void'(frame_score_q.pop_front());
                end
            end
        end
    end

    // sender: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!pix.valid || pix_taken))
        begin
            if (pixel_q.size() == 0)
                pix.valid <= 1'b0;
            else if (gap_left != 0)
            begin
                gap_left--;
                pix.valid <= 1'b0;
            end
            else
            begin
                next_pair = pixel_q.pop_front();
                pix.valid      <= 1'b1;
                pix.orig_pixel <= next_pair.orig;
                pix.test_pixel <= next_pair.test;
                pix.last_pixel <= next_pair.last;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left--;
            end
        end
    end

    // receiver: stall pattern per window, plus one long hold to back up the block
    always @(negedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else if (!held_once && frames_scored >= HOLD_AT_FRAME)
        begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            res.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(10, 80);
                stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
            end
            mode_left--;
            res.ready <= stall_pat[pat_idx];
            pat_idx = pat_idx + 3'(1);
        end
    end

    task automatic queue_pair(input logic [PIX_W-1:0] o, input logic [PIX_W-1:0] t,
                              input logic last);
        pixel_pair_t p;
        while (pixel_q.size() >= QUEUE_DEPTH)
            @(posedge clk);
        p.orig = o;
        p.test = t;
        p.last = last;
        pixel_q.push_back(p);
    endtask

    task automatic queue_frame(input int unsigned len, input frame_style_t style);
        int unsigned      k;
        int unsigned      spot;
        logic [PIX_W-1:0] o;
        logic [PIX_W-1:0] t;
        spot = $urandom_range(0, len - 1);
        for (k = 0; k < len; k++)
        begin
            o = PIX_W'($urandom);
            case (style)
                FRAME_NOISE:   t = PIX_W'($urandom);
                FRAME_CLOSE:   t = o + PIX_W'($urandom_range(0, 6)) - PIX_W'(3);
                FRAME_SAME:    t = o;
                FRAME_SPECK:   t = (k == spot) ? PIX_W'($urandom) : o;
                default:
                begin
                    o = $urandom_range(0, 1) ? '1 : '0;
                    t = $urandom_range(0, 3) ? ~o : o;
                end
            endcase
            queue_pair(o, t, k == len - 1);
        end
    endtask

    // random frames, mostly short, now and then a longer one
    task automatic queue_random_frames(input int unsigned items);
        int unsigned  sent;
        int unsigned  len;
        frame_style_t style;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1, 2: style = FRAME_NOISE;
                3, 4, 5: style = FRAME_CLOSE;
                6:       style = FRAME_SAME;
                7, 8:    style = FRAME_SPECK;
                default: style = FRAME_EXTREME;
            endcase
            queue_frame(len, style);
            sent += len;
        end
    endtask

    // all pairs sent and all scores back
    task automatic wait_idle();
        @(posedge clk);
        while (pixel_q.size() != 0 || pix.valid || frame_score_q.size() != 0)
            @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic set_depth(input logic [DEPTH_W-1:0] value);
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_data  <= value;
        cur_depth = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        pix.valid      = 1'b0;
        pix.orig_pixel = '0;
        pix.test_pixel = '0;
        pix.last_pixel = 1'b0;
        res.ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        rst_n          = 1'b0;

        // directed frames at the reset depth
        queue_pair(8'd0, 8'd0, 1'b1);       // identical single pair
        queue_pair(8'd255, 8'd0, 1'b1);     // largest error
        queue_pair(8'd0, 8'd255, 1'b1);
        queue_pair(8'd170, 8'd85, 1'b1);
        queue_pair(8'd85, 8'd170, 1'b1);
        queue_pair(8'd100, 8'd101, 1'b1);   // above 40 dB
        queue_pair(8'd100, 8'd103, 1'b1);   // 30..40 dB
        queue_pair(8'd50, 8'd60, 1'b1);     // 20..30 dB
        queue_pair(8'd128, 8'd128, 1'b0);   // identical multi-pair frame
        queue_pair(8'd128, 8'd128, 1'b0);
        queue_pair(8'd128, 8'd128, 1'b1);
        queue_pair(8'd255, 8'd255, 1'b0);
        queue_pair(8'd0, 8'd1, 1'b0);
        queue_pair(8'd200, 8'd10, 1'b0);
        queue_pair(8'd7, 8'd7, 1'b1);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        queue_random_frames(PHASE_ITEMS);

        // smallest depth: PSNR goes negative
        set_depth(DEPTH_W'(1));
        queue_pair(8'd255, 8'd0, 1'b1);
        queue_pair(8'd1, 8'd0, 1'b1);
        queue_pair(8'd0, 8'd0, 1'b1);
        queue_random_frames(PHASE_ITEMS);

        set_depth(DEPTH_W'(16));
        queue_random_frames(PHASE_ITEMS);

        // out-of-range depths clamp to 1 and 16
        set_depth(DEPTH_W'(0));
        queue_random_frames(PHASE_ITEMS);

        set_depth(DEPTH_W'(31));
        queue_random_frames(PHASE_ITEMS);

        set_depth(DEPTH_W'($urandom_range(2, 15)));
        queue_random_frames(PHASE_ITEMS);

        set_depth(DEPTH_W'($urandom_range(17, 30)));
        queue_random_frames(PHASE_ITEMS);

        set_depth(DEPTH_W'(8));
        queue_random_frames(PHASE_ITEMS);
        queue_frame(5, FRAME_NOISE);

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // no transfer on either channel for too long
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
